>>> rtl/bounded_queue_sorted_dump_macros.svh
// Assertion helpers for the queue RTL (used by the top-level queue module).
// Both expect clk and rst_n in the calling scope.
`ifndef BOUNDED_QUEUE_SORTED_DUMP_MACROS_SVH
`define BOUNDED_QUEUE_SORTED_DUMP_MACROS_SVH

// Same-cycle implication.
`define BQSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BQSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bqsd_pkg.sv
package bqsd_pkg;

    localparam int KEY_W  = 32;
    localparam int RANK_W = 3;
    localparam int OCC_W  = 4;

    typedef enum logic [1:0] {
        REQ_ENQ  = 2'd0,
        REQ_DEQ  = 2'd1,
        REQ_CLR  = 2'd2,
        REQ_VIEW = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // request word taken this cycle
        logic scan;     // sort scan in progress
        logic deq_put;  // publish dequeued key
        logic emit;     // publish current minimum of the scan
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;
        logic view_go;
        logic deq_go;
        logic scan_done;
        logic last_rank;
    } sts_t;

endpackage

>>> rtl/bqsd_req_if.sv
interface bqsd_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          req_type;
    logic signed [bqsd_pkg::KEY_W-1:0]   entry_key;

    modport source (output valid, output req_type, output entry_key, input ready);
    modport sink   (input valid, input req_type, input entry_key, output ready);
endinterface

>>> rtl/bqsd_rsp_if.sv
interface bqsd_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic signed [bqsd_pkg::KEY_W-1:0]   key_out;
    logic [bqsd_pkg::RANK_W-1:0]         rank;
    logic [bqsd_pkg::OCC_W-1:0]          occupancy;
    logic                                last;

    modport source (output valid, output status, output key_out, output rank,
                    output occupancy, output last, input ready);
    modport sink   (input valid, input status, input key_out, input rank,
                    input occupancy, input last, output ready);
endinterface

>>> rtl/bqsd_ctrl.sv
module bqsd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  bqsd_pkg::sts_t   sts,
    output bqsd_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DEQ  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready    = (state_reg == S_IDLE) && !sts.out_busy;
    assign cmd.accept  = in_valid && in_ready;
    assign cmd.scan    = (state_reg == S_SCAN);
    assign cmd.emit    = (state_reg == S_SCAN) && sts.scan_done && !sts.out_busy;
    assign cmd.deq_put = (state_reg == S_DEQ);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept && sts.view_go)
                    state_next = S_SCAN;
                else if (cmd.accept && sts.deq_go)
                    state_next = S_DEQ;
            end
            S_SCAN:
            begin
                if (cmd.emit && sts.last_rank)
                    state_next = S_IDLE;
            end
            S_DEQ:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/bqsd_datapath.sv
module bqsd_datapath #(
    parameter int DEPTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bqsd_pkg::cmd_t                      cmd,
    output bqsd_pkg::sts_t                      sts,
    input  logic [1:0]                          req_type,
    input  logic signed [bqsd_pkg::KEY_W-1:0]   entry_key,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic signed [bqsd_pkg::KEY_W-1:0]   key_out,
    output logic [bqsd_pkg::RANK_W-1:0]         rank,
    output logic [bqsd_pkg::OCC_W-1:0]          occupancy,
    output logic                                last
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = IW + 2;
    localparam int KW = bqsd_pkg::KEY_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [KW-1:0] KEY_BIAS = {1'b1, {(KW - 1){1'b0}}};

    logic [KW-1:0] mem [DEPTH];

    logic [IW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ise_reg, ise_next;

    logic [CW-1:0] issue_reg;
    logic [KW-1:0] rd_data_reg;
    logic [IW-1:0] rd_pos_reg;
    logic          rd_vld_reg;
    logic [KW-1:0] best_key_reg;
    logic [IW-1:0] best_pos_reg;
    logic          best_vld_reg;
    logic [KW-1:0] prev_key_reg;
    logic [IW-1:0] prev_pos_reg;
    logic [IW-1:0] rank_reg;

    logic                 out_valid_reg;
    bqsd_pkg::status_t    out_status_reg;
    logic [KW-1:0]        out_key_reg;
    logic [bqsd_pkg::RANK_W-1:0] out_rank_reg;
    logic [bqsd_pkg::OCC_W-1:0]  out_occ_reg;
    logic                 out_last_reg;

    logic          is_full, is_empty;
    logic [SW-1:0] wr_sum, scan_sum, inc_sum;
    logic [IW-1:0] wr_addr, scan_addr, ptr_inc, rd_addr;
    logic          mem_we, issuing, simple_load, load;
    logic [KW-1:0] cand_b, prev_b, best_b;
    logic          eligible, better, take;
    logic [31:0]   rank_ext, occ_ext;
    bqsd_pkg::status_t simple_status;

    assign is_full  = (ise_reg >= DEPTH_C);
    assign is_empty = (count_reg == '0);

    // circular addressing, sums stay below twice the depth
    assign wr_sum    = SW'(rd_ptr_reg) + SW'(count_reg);
    assign wr_addr   = (wr_sum >= DEPTH_S) ? IW'(wr_sum - DEPTH_S) : IW'(wr_sum);
    assign scan_sum  = SW'(rd_ptr_reg) + SW'(issue_reg);
    assign scan_addr = (scan_sum >= DEPTH_S) ? IW'(scan_sum - DEPTH_S) : IW'(scan_sum);
    assign inc_sum   = SW'(rd_ptr_reg) + SW'(1);
    assign ptr_inc   = (inc_sum == DEPTH_S) ? '0 : IW'(inc_sum);
    assign rd_addr   = cmd.scan ? scan_addr : rd_ptr_reg;

    assign mem_we  = cmd.accept && (req_type == bqsd_pkg::REQ_ENQ) && !is_full;
    assign issuing = cmd.scan && (issue_reg != count_reg);

    assign sts.out_busy  = out_valid_reg && !out_ready;
    assign sts.view_go   = (req_type == bqsd_pkg::REQ_VIEW) && !is_empty;
    assign sts.deq_go    = (req_type == bqsd_pkg::REQ_DEQ) && !is_empty;
    assign sts.scan_done = (issue_reg == count_reg) && !rd_vld_reg;
    assign sts.last_rank = ((CW'(rank_reg) + CW'(1)) == count_reg);

    // signed order via biased unsigned compare; ties go to arrival position
    assign cand_b   = rd_data_reg ^ KEY_BIAS;
    assign prev_b   = prev_key_reg ^ KEY_BIAS;
    assign best_b   = best_key_reg ^ KEY_BIAS;
    assign eligible = (rank_reg == '0) || (cand_b > prev_b) ||
                      ((cand_b == prev_b) && (rd_pos_reg > prev_pos_reg));
    assign better   = !best_vld_reg || (cand_b < best_b);
    assign take     = rd_vld_reg && eligible && better;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        ise_next    = ise_reg;
        if (cmd.accept)
        begin
            case (req_type)
                bqsd_pkg::REQ_ENQ:
                begin
                    if (!is_full)
                    begin
                        count_next = count_reg + CW'(1);
                        ise_next   = ise_reg + CW'(1);
                    end
                end
                bqsd_pkg::REQ_DEQ:
                begin
                    if (count_reg == CW'(1))
                    begin
                        rd_ptr_next = '0;
                        count_next  = '0;
                        ise_next    = '0;
                    end
                    else if (!is_empty)
                    begin
                        rd_ptr_next = ptr_inc;
                        count_next  = count_reg - CW'(1);
                    end
                end
                bqsd_pkg::REQ_CLR:
                begin
                    rd_ptr_next = '0;
                    count_next  = '0;
                    ise_next    = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign simple_load = cmd.accept && !sts.view_go && !sts.deq_go;
    assign load        = simple_load || cmd.deq_put || cmd.emit;
    assign rank_ext    = 32'(rank_reg);
    assign occ_ext     = 32'(count_next);

    always_comb
    begin
        case (req_type)
            bqsd_pkg::REQ_ENQ:  simple_status = is_full ? bqsd_pkg::ST_FULL : bqsd_pkg::ST_OK;
            bqsd_pkg::REQ_DEQ:  simple_status = bqsd_pkg::ST_EMPTY;
            bqsd_pkg::REQ_VIEW: simple_status = bqsd_pkg::ST_EMPTY;
            default:            simple_status = bqsd_pkg::ST_OK;
        endcase
    end

    // key storage, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= entry_key;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            ise_reg       <= '0;
            issue_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            best_vld_reg  <= 1'b0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            ise_reg    <= ise_next;

            if (cmd.accept && sts.view_go)
            begin
                issue_reg    <= '0;
                rd_vld_reg   <= 1'b0;
                best_vld_reg <= 1'b0;
                rank_reg     <= '0;
            end
            else if (cmd.emit)
            begin
                issue_reg    <= '0;
                rd_vld_reg   <= 1'b0;
                best_vld_reg <= 1'b0;
                rank_reg     <= rank_reg + IW'(1);
            end
            else
            begin
                rd_vld_reg <= issuing;
                if (issuing)
                    issue_reg <= issue_reg + CW'(1);
                if (take)
                    best_vld_reg <= 1'b1;
            end

            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issuing)
            rd_pos_reg <= IW'(issue_reg);
        if (take)
        begin
            best_key_reg <= rd_data_reg;
            best_pos_reg <= rd_pos_reg;
        end
        if (cmd.emit)
        begin
            prev_key_reg <= best_key_reg;
            prev_pos_reg <= best_pos_reg;
        end

        if (cmd.emit)
        begin
            out_status_reg <= bqsd_pkg::ST_OK;
            out_key_reg    <= best_key_reg;
            out_rank_reg   <= rank_ext[bqsd_pkg::RANK_W-1:0];
            out_occ_reg    <= occ_ext[bqsd_pkg::OCC_W-1:0];
            out_last_reg   <= sts.last_rank;
        end
        else if (cmd.deq_put)
        begin
            out_status_reg <= bqsd_pkg::ST_OK;
            out_key_reg    <= rd_data_reg;
            out_rank_reg   <= '0;
            out_occ_reg    <= occ_ext[bqsd_pkg::OCC_W-1:0];
            out_last_reg   <= 1'b1;
        end
        else if (simple_load)
        begin
            out_status_reg <= simple_status;
            out_key_reg    <= '0;
            out_rank_reg   <= '0;
            out_occ_reg    <= occ_ext[bqsd_pkg::OCC_W-1:0];
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign key_out   = out_key_reg;
    assign rank      = out_rank_reg;
    assign occupancy = out_occ_reg;
    assign last      = out_last_reg;

endmodule

>>> rtl/bounded_queue_sorted_dump.sv
// Enqueue, clear and empty requests: result word registered at the accepting edge.
// Dequeue: the key is read through the registered memory read port in the S_DEQ
// state, then the result word is registered. Sorted view of n keys: each rank
// re-scans all n entries through the single memory read port to find the next key in order.
// A new request is taken only in the idle state and while the result word is not stalled.
// Reset (rst_n, async low) empties the queue; key memory contents are not cleared.
`include "bounded_queue_sorted_dump_macros.svh"

module bounded_queue_sorted_dump #(
    parameter int DEPTH = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    bqsd_req_if.sink     req,
    bqsd_rsp_if.source   rsp
);

    // Command and status between sequencer and datapath
    bqsd_pkg::cmd_t cmd;
    bqsd_pkg::sts_t sts;

    // Result word held back by the receiver; non-empty dequeue taken
    logic out_stall;
    logic deq_start;

    // Sequencer: idle / sort scan / dequeue publish
    bqsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: key memory, pointers, occupancy, selection scan, result word
    bqsd_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_type  (req.req_type),
        .entry_key (req.entry_key),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (rsp.status),
        .key_out   (rsp.key_out),
        .rank      (rsp.rank),
        .occupancy (rsp.occupancy),
        .last      (rsp.last)
    );

    assign out_stall = rsp.valid && !rsp.ready;
    assign deq_start = cmd.accept && sts.deq_go;

    // A request word is only taken when the result register can accept its answer
    `BQSD_ASSERT_IMP(a_accept_free, cmd.accept, !out_stall, "accept under output stall")
    // Each scan emit shows up as a result word
    `BQSD_ASSERT_NXT(a_emit_loads, cmd.emit, rsp.valid, "emit did not load result")
    // Non-empty dequeue: memory read cycle, then the result word
    `BQSD_ASSERT_NXT(a_deq_timing, deq_start, !rsp.valid ##1 rsp.valid, "dequeue result timing")

endmodule

>>> tb/bounded_queue_sorted_dump_tb.sv
`timescale 1ns / 1ps

module bounded_queue_sorted_dump_tb;

    localparam int DEPTH      = 8;
    localparam int WATCHDOG   = 2000;  // cycles with no word accepted on either side
    localparam int SETTLE     = 100;
    localparam int N_RANDOM   = 95;

    localparam logic signed [bqsd_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fffffff;
    localparam logic signed [bqsd_pkg::KEY_W-1:0] KEY_MIN = 32'sh80000000;

    // One request word waiting to be driven. drain = hold it back until
    // every outstanding result has come out.
    typedef struct packed {
        bqsd_pkg::req_t                     req;
        logic signed [bqsd_pkg::KEY_W-1:0]  key;
        logic                               drain;
    } req_word_t;

    typedef struct {
        bqsd_pkg::status_t                  status;
        logic signed [bqsd_pkg::KEY_W-1:0]  key;
        logic [bqsd_pkg::RANK_W-1:0]        rank;
        logic [bqsd_pkg::OCC_W-1:0]         occ;
        logic                               last;
    } result_t;

    logic clk;
    logic rst_n;

    bqsd_req_if req_ch ();
    bqsd_rsp_if rsp_ch ();

    bounded_queue_sorted_dump #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Words not yet accepted, and results not yet seen.
    req_word_t pending_words[$];
    result_t   expected_results[$];

    // Queue model: key slots, oldest slot, entries held, and keys taken
    // since the queue was last empty (the full flag keys off the latter).
    logic signed [bqsd_pkg::KEY_W-1:0] model_keys [DEPTH];
    int model_head;
    int model_count;
    int model_fills;

    int n_total;
    int n_sent;
    int n_results;
    int n_views;
    int n_refused;
    int n_empty;
    int n_errors;
    int idle_cycles;
    bit word_taken;
    int cur_phase;

    // Idle percentages per phase: sender/receiver busy, then swapped, then none.
    int tx_idle_pct [3] = '{25, 58, 0};
    int rx_idle_pct [3] = '{58, 25, 0};

    task automatic add_word(bqsd_pkg::req_t r, logic signed [bqsd_pkg::KEY_W-1:0] k,
                            logic drain);
        req_word_t w;
        w.req   = r;
        w.key   = k;
        w.drain = drain;
        pending_words.insert(pending_words.size(), w);
    endtask

    // Mix of tie-prone small keys, extremes and full-range keys.
    function automatic logic signed [bqsd_pkg::KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return bqsd_pkg::KEY_W'($signed($urandom_range(0, 8)) - 4);
        else if (sel == 3)
            return ($urandom_range(0, 1) == 1) ? KEY_MAX : KEY_MIN;
        else
            return $urandom;
    endfunction

    function automatic void queue_result(bqsd_pkg::status_t s,
                                         logic signed [bqsd_pkg::KEY_W-1:0] k,
                                         int rank, int occ, logic last);
        result_t r;
        r.status = s;
        r.key    = k;
        r.rank   = rank[bqsd_pkg::RANK_W-1:0];
        r.occ    = occ[bqsd_pkg::OCC_W-1:0];
        r.last   = last;
        expected_results.insert(expected_results.size(), r);
    endfunction

    // Work out the results of one accepted request and update the model.
    task automatic predict_request(bqsd_pkg::req_t r, logic signed [bqsd_pkg::KEY_W-1:0] k);
        logic signed [bqsd_pkg::KEY_W-1:0] ordered [DEPTH];
        logic signed [bqsd_pkg::KEY_W-1:0] v;
        int j;
        case (r)
            bqsd_pkg::REQ_ENQ:
            begin
                if (model_fills >= DEPTH || model_count >= DEPTH)
                begin
                    n_refused++;
                    queue_result(bqsd_pkg::ST_FULL, '0, 0, model_count, 1'b1);
                end
                else
                begin
                    model_keys[(model_head + model_count) % DEPTH] = k;
                    model_count++;
                    model_fills++;
                    queue_result(bqsd_pkg::ST_OK, '0, 0, model_count, 1'b1);
                end
            end
            bqsd_pkg::REQ_DEQ:
            begin
                if (model_count == 0)
                begin
                    n_empty++;
                    queue_result(bqsd_pkg::ST_EMPTY, '0, 0, 0, 1'b1);
                end
                else
                begin
                    v = model_keys[model_head];
                    model_head = (model_head + 1) % DEPTH;
                    model_count--;
                    if (model_count == 0)
                    begin
                        model_head  = 0;
                        model_fills = 0;
                    end
                    queue_result(bqsd_pkg::ST_OK, v, 0, model_count, 1'b1);
                end
            end
            bqsd_pkg::REQ_CLR:
            begin
                model_head  = 0;
                model_count = 0;
                model_fills = 0;
                queue_result(bqsd_pkg::ST_OK, '0, 0, 0, 1'b1);
            end
            default:
            begin
                n_views++;
                if (model_count == 0)
                begin
                    n_empty++;
                    queue_result(bqsd_pkg::ST_EMPTY, '0, 0, 0, 1'b1);
                end
                else
                begin
                    // stable insertion sort in arrival order, signed compare
                    for (int i = 0; i < model_count; i++)
                    begin
                        v = model_keys[(model_head + i) % DEPTH];
                        j = i;
                        while (j > 0 && ordered[j - 1] > v)
                        begin
                            ordered[j] = ordered[j - 1];
                            j--;
                        end
                        ordered[j] = v;
                    end
                    for (int i = 0; i < model_count; i++)
                        queue_result(bqsd_pkg::ST_OK, ordered[i], i, model_count,
                                     i == model_count - 1);
                end
            end
        endcase
    endtask

    task automatic check_field(string name, logic [bqsd_pkg::KEY_W-1:0] want,
                               logic [bqsd_pkg::KEY_W-1:0] got);
        if (want !== got)
        begin
            n_errors++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Driver: request word and receiver ready change at the falling edge.
    // A presented word is held until it is taken.
    always @(negedge clk)
    begin : drive
        req_word_t w;
        bit        go;
        if (rst_n)
        begin
            if (!req_ch.valid || word_taken)
            begin
                go = 1'b0;
                if (pending_words.size() > 0)
                begin
                    w = pending_words[0];
                    cur_phase = (n_sent * 3) / n_total;
                    go = ($urandom_range(0, 99) >= tx_idle_pct[cur_phase]) &&
                         (!w.drain || expected_results.size() == 0);
                end
                if (go)
                begin
                    req_ch.valid     <= 1'b1;
                    req_ch.req_type  <= w.req;
                    req_ch.entry_key <= w.key;
                end
                else
                    req_ch.valid <= 1'b0;
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct[cur_phase]);
        end
    end

    // Monitor: both channels sampled at the rising edge. Results are checked
    // before the new request is predicted; a result never belongs to a
    // request accepted at the same edge.
    always @(posedge clk)
    begin : observe
        result_t e;
        word_taken = 1'b0;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_results++;
                if (expected_results.size() == 0)
                begin
                    n_errors++;
                    $display("%0t ns: result word with nothing expected, key %0h",
                             $time, rsp_ch.key_out);
                end
                else
                begin
                    e = expected_results.pop_front();
                    check_field("status",    e.status, rsp_ch.status);
                    check_field("key_out",   e.key,    rsp_ch.key_out);
                    check_field("rank",      e.rank,   rsp_ch.rank);
                    check_field("occupancy", e.occ,    rsp_ch.occupancy);
                    check_field("last",      e.last,   rsp_ch.last);
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                predict_request(bqsd_pkg::req_t'(req_ch.req_type), req_ch.entry_key);
                void'(pending_words.pop_front());
                word_taken = 1'b1;
                n_sent++;
            end
        end
    end

    // Watchdog: any cycle without an accepted word on either side counts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("timeout: no word accepted for %0d cycles, %0d results outstanding",
                         WATCHDOG, expected_results.size());
                $display("FAIL bounded_queue_sorted_dump");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int n_directed;
        int burst;
        int drops;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = bqsd_pkg::REQ_ENQ;
        req_ch.entry_key = '0;
        rsp_ch.ready     = 1'b0;
        model_head  = 0;
        model_count = 0;
        model_fills = 0;
        n_sent      = 0;
        n_results   = 0;
        n_views     = 0;
        n_refused   = 0;
        n_empty     = 0;
        n_errors    = 0;
        idle_cycles = 0;
        word_taken  = 1'b0;
        cur_phase   = 0;

        // Directed: empty view and dequeue, extreme keys with ties, filling
        // to full, refused enqueue, the sticky full after a dequeue, clear,
        // a dequeue that empties the queue, and a view after reuse.
        add_word(bqsd_pkg::REQ_VIEW, '0, 1'b0);
        add_word(bqsd_pkg::REQ_DEQ,  '0, 1'b0);
        add_word(bqsd_pkg::REQ_ENQ,  KEY_MAX, 1'b0);
        add_word(bqsd_pkg::REQ_ENQ,  KEY_MIN, 1'b0);
        add_word(bqsd_pkg::REQ_ENQ,  0, 1'b0);
        add_word(bqsd_pkg::REQ_ENQ,  -1, 1'b0);
        add_word(bqsd_pkg::REQ_ENQ,  5, 1'b0);
        add_word(bqsd_pkg::REQ_ENQ,  5, 1'b0);
        add_word(bqsd_pkg::REQ_ENQ,  -1, 1'b0);
        add_word(bqsd_pkg::REQ_ENQ,  KEY_MIN, 1'b0);
        add_word(bqsd_pkg::REQ_ENQ,  123, 1'b0);      // full: refused
        add_word(bqsd_pkg::REQ_VIEW, '0, 1'b0);
        add_word(bqsd_pkg::REQ_DEQ,  KEY_MAX, 1'b0);
        add_word(bqsd_pkg::REQ_ENQ,  9, 1'b0);        // still full after a dequeue
        add_word(bqsd_pkg::REQ_VIEW, '0, 1'b0);
        add_word(bqsd_pkg::REQ_DEQ,  '0, 1'b0);
        add_word(bqsd_pkg::REQ_DEQ,  '0, 1'b0);
        add_word(bqsd_pkg::REQ_CLR,  KEY_MAX, 1'b0);
        add_word(bqsd_pkg::REQ_VIEW, '0, 1'b0);
        add_word(bqsd_pkg::REQ_ENQ,  42, 1'b1);       // wait for outstanding results to drain
        add_word(bqsd_pkg::REQ_DEQ,  '0, 1'b0);       // empties the queue
        add_word(bqsd_pkg::REQ_ENQ,  -7, 1'b0);
        add_word(bqsd_pkg::REQ_ENQ,  3, 1'b0);
        add_word(bqsd_pkg::REQ_VIEW, '0, 1'b0);
        add_word(bqsd_pkg::REQ_DEQ,  '0, 1'b0);
        n_directed = pending_words.size();

        // Random: mostly fill / view / drain episodes, some of them running
        // past full, with single random requests as noise.
        while (pending_words.size() - n_directed < N_RANDOM)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                burst = $urandom_range(1, DEPTH + 2);
                for (int i = 0; i < burst; i++)
                    add_word(bqsd_pkg::REQ_ENQ, pick_key(), $urandom_range(0, 39) == 0);
                add_word(bqsd_pkg::REQ_VIEW, $urandom, 1'b0);
                drops = $urandom_range(0, burst);
                for (int i = 0; i < drops; i++)
                    add_word(bqsd_pkg::REQ_DEQ, $urandom, 1'b0);
                if ($urandom_range(0, 1) == 1)
                    add_word(bqsd_pkg::REQ_VIEW, $urandom, 1'b0);
                if ($urandom_range(0, 3) == 0)
                    add_word(bqsd_pkg::REQ_CLR, $urandom, 1'b0);
            end
            else
                add_word(bqsd_pkg::req_t'($urandom_range(0, 3)), pick_key(), 1'b0);
        end
        n_total = pending_words.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (n_sent < n_total || expected_results.size() > 0)
            @(posedge clk);
        // let any stray trailing result show up
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d requests: %0d views, %0d refused enqueues, %0d empty statuses;",
                 n_sent, n_views, n_refused, n_empty);
        $display("%0d result words checked under three sender/receiver stall mixes.",
                 n_results);
        if (n_errors == 0)
            $display("PASS bounded_queue_sorted_dump");
        else
            $display("FAIL bounded_queue_sorted_dump");
        $finish;
    end

endmodule
